[rtl/ssedl_pkg.sv]
// Shared constants, types and the line character step of the data-line deframer.
package ssedl_pkg;

   // Character codes
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Line stage codes: 0..4 count matched prefix characters
   localparam int          STAGE_W         = 3;
   localparam logic [2:0]  STAGE_START     = 3'd0;
   localparam logic [2:0]  STAGE_OPT_SPACE = 3'd5;
   localparam logic [2:0]  STAGE_PAYLOAD   = 3'd6;
   localparam logic [2:0]  STAGE_DISCARD   = 3'd7;

   // Default depth of the result queue
   localparam int RSP_DEPTH_DEFAULT = 4;

   // Result of one committed line character
   typedef struct packed {
      logic [STAGE_W-1:0] stage;
      logic               has_data;
      logic               emit;
      logic [7:0]         data;
   } char_out_type;

   // Up to two results of one input word, in delivery order
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] data0;
      logic       mark0;
      logic [7:0] data1;
      logic       mark1;
   } step_out_type;

   // Expected character of the "data:" prefix at each matched position
   function automatic logic [7:0] prefix_char(input logic [STAGE_W-1:0] stage);
      logic [7:0] c;
      case (stage)
         3'd0:    c = 8'h64; // d
         3'd1:    c = 8'h61; // a
         3'd2:    c = 8'h74; // t
         3'd3:    c = 8'h61; // a
         3'd4:    c = 8'h3A; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Advance the line state by one committed character
   function automatic char_out_type line_char(input logic [7:0] c,
                                              input logic [STAGE_W-1:0] stage,
                                              input logic has_data);
      char_out_type r;
      r.stage    = stage;
      r.has_data = has_data;
      r.emit     = 1'b0;
      r.data     = c;
      if (stage < STAGE_OPT_SPACE) begin
         if (c == prefix_char(stage)) begin
            r.stage = stage + 3'd1;
            // separator before a further data line of the event
            if (r.stage == STAGE_OPT_SPACE && has_data) begin
               r.emit = 1'b1;
               r.data = CH_LF;
            end
         end else begin
            r.stage = STAGE_DISCARD;
         end
      end else if (stage == STAGE_OPT_SPACE) begin
         r.stage = STAGE_PAYLOAD;
         if (c != CH_SPACE) begin
            r.emit     = 1'b1;
            r.has_data = 1'b1;
         end
      end else if (stage == STAGE_PAYLOAD) begin
         r.emit     = 1'b1;
         r.has_data = 1'b1;
      end
      return r;
   endfunction

endpackage

[rtl/ssedl_parse.sv]
// Line parser: holds the line and event state and turns one word into up to two results.
module ssedl_parse
   import ssedl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic [7:0]   in_byte,
   output step_out_type step_out
);

   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic               held_ff, held_in;
   logic               content_ff, content_in;
   logic               has_data_ff, has_data_in;

   char_out_type       first_res;
   char_out_type       second_res;
   logic               do_first;
   logic               do_second;
   logic [STAGE_W-1:0] mid_stage;
   logic               mid_has_data;
   logic               is_lf;
   logic               is_cr;

   assign is_lf = (in_byte == CH_LF);
   assign is_cr = (in_byte == CH_CR);

   // Release a held CR before anything but LF; then handle the word itself
   assign do_first     = held_ff && !is_lf;
   assign do_second    = !is_lf && !is_cr;
   assign first_res    = line_char(CH_CR, stage_ff, has_data_ff);
   assign mid_stage    = do_first ? first_res.stage : stage_ff;
   assign mid_has_data = do_first ? first_res.has_data : has_data_ff;
   assign second_res   = line_char(in_byte, mid_stage, mid_has_data);

   // Work out results and next state
   always_comb begin
      stage_in         = stage_ff;
      held_in          = held_ff;
      content_in       = content_ff;
      has_data_in      = has_data_ff;
      step_out         = '0;
      if (is_lf) begin
         held_in    = 1'b0;
         stage_in   = STAGE_START;
         content_in = 1'b0;
         // blank line closes a non-empty event
         if (!content_ff && has_data_ff) begin
            step_out.count = 2'd1;
            step_out.data0 = 8'h00;
            step_out.mark0 = 1'b1;
            has_data_in    = 1'b0;
         end
      end else begin
         held_in     = is_cr;
         content_in  = content_ff || do_first || do_second;
         stage_in    = do_second ? second_res.stage : mid_stage;
         has_data_in = do_second ? second_res.has_data : mid_has_data;
         if (do_first && first_res.emit) begin
            step_out.count = 2'd1;
            step_out.data0 = first_res.data;
            if (do_second && second_res.emit) begin
               step_out.count = 2'd2;
               step_out.data1 = second_res.data;
            end
         end else if (do_second && second_res.emit) begin
            step_out.count = 2'd1;
            step_out.data0 = second_res.data;
         end
      end
   end

   // Hold state, advance on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= STAGE_START;
         held_ff     <= 1'b0;
         content_ff  <= 1'b0;
         has_data_ff <= 1'b0;
      end else if (fire) begin
         stage_ff    <= stage_in;
         held_ff     <= held_in;
         content_ff  <= content_in;
         has_data_ff <= has_data_in;
      end
   end

endmodule

[rtl/sse_data_line_deframer_core.sv]
// Top level of the server-sent-events data-line deframer.
// Takes the event stream one byte word per cycle while req_stall is low and delivers the
// payload bytes of "data:" lines, LF separators between data lines of one event, and an
// end marker (event_end high, byte zero) when a blank line closes a non-empty event. An
// accepted word is registered, processed by the line parser once the queue has room for
// two more results, and its zero, one or two results are written into a result queue of
// RSP_DEPTH entries. A new word is accepted every cycle while the queue has room for two
// more results; the queue drains one result per cycle while rsp_stall is low, so words
// that give two results set the sustained rate at the output side. The first result of a
// word passes the input register and the result queue before it is offered.
module sse_data_line_deframer_core
   import ssedl_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_event_end
);

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RSP_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(RSP_DEPTH - 2);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             req_take;
   logic             fire;
   step_out_type     step_out;

   logic [8:0]       queue_mem [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_nx;
   logic             pop;

   // Input register: take a word while the previous one is processed or gone
   assign fire        = in_valid_ff && (count_ff <= CNT_ROOM2);
   assign req_stall   = in_valid_ff && !fire;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   ssedl_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .in_byte  (in_byte_ff),
      .step_out (step_out)
   );

   // Result queue pointers
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_nx = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (fire && step_out.count == 2'd1) begin
         wr_ptr_in = wr_ptr_nx;
      end else if (fire && step_out.count == 2'd2) begin
         wr_ptr_in = (wr_ptr_nx == PTR_LAST) ? '0 : wr_ptr_nx + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (fire ? CNT_W'(step_out.count) : '0) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write results into the queue
   always_ff @(posedge clock) begin
      if (fire && step_out.count != 2'd0) begin
         queue_mem[wr_ptr_ff] <= {step_out.data0, step_out.mark0};
      end
      if (fire && step_out.count == 2'd2) begin
         queue_mem[wr_ptr_nx] <= {step_out.data1, step_out.mark1};
      end
   end

   // Present the oldest result
   assign rsp_valid     = (count_ff != '0);
   assign rsp_out_byte  = queue_mem[rd_ptr_ff][8:1];
   assign rsp_event_end = queue_mem[rd_ptr_ff][0];

endmodule

[rtl/ssedl_checker.sv]
// Port-level checker for the data-line deframer, bound to the top level.
module ssedl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_event_end
);

   // Nothing to deliver straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // End marker carries a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_end |-> rsp_out_byte == 8'h00)
      else $error("end marker with non-zero byte");

   // Two end markers never follow each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_event_end |=> !(rsp_valid && rsp_event_end))
      else $error("end marker repeated without data between");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_event_end))
      else $error("stalled result changed");

   // A stalled stream word holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("stalled stream word changed");

endmodule

bind sse_data_line_deframer_core ssedl_checker u_ssedl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_in_byte   (req_in_byte),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_event_end (rsp_event_end)
);
